// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DSTT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dstt assertion failed");

// checked at every edge, reset included
`define DSTT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("dstt assertion failed during or after reset");

`endif

// ===== rtl/core/dstt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstt_pkg
// types and constants of the deadline slot timer table
// ----------------------------------------------------------------------------
package dstt_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int MAX_RES   = 8;
	localparam int CNT_W     = $clog2(MAX_RES + 1);
	localparam int IN_W      = 320;
	localparam int OUT_W     = 256;
	localparam logic [15:0] CONN_ANY = 16'hFFFF;
	localparam logic [63:0] TIME_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		REQ_APPLY   = 3'd0,
		REQ_COLLECT = 3'd1,
		REQ_RETIRE  = 3'd2,
		REQ_REMAIN  = 3'd3,
		REQ_READ    = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_FINAL
	} state_t;

	// one stored slot record
	typedef struct packed {
		logic [31:0] revision;
		logic [31:0] generation;
		logic [31:0] epoch;
		logic [31:0] flow;
		logic [31:0] token;
		logic [7:0]  op_kind;
		logic [15:0] conn;
		logic [63:0] deadline;
	} rec_t;

	// one result
	typedef struct packed {
		logic        ok;
		logic [2:0]  slot;
		logic        armed;
		logic [31:0] revision;
		logic [31:0] generation;
		logic [31:0] epoch;
		logic [31:0] flow;
		logic [31:0] token;
		logic [7:0]  op_kind;
		logic [15:0] conn;
		logic [63:0] time_us;
		logic        last;
	} res_t;

endpackage

// ===== rtl/core/dstt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dstt_ram #(
	parameter int W = 8,
	parameter int D = 8
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                       wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                       rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/deadline_slot_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_slot_timer_table_unit
// table of deadline slots with apply, collect, retire, remaining and read
// requests, worked through one ram read port and one 64-bit subtractor
// ----------------------------------------------------------------------------
// channel  dir  handshake            tdata / tuser / tlast
// s        in   s_tvalid, s_tready   request fields / req_type / -
// m        out  m_tvalid, m_tready   result fields / ok / last result
//
// apply, retire, read and unknown requests: a fetch step reads the slot, then the
// exec step registers the result once the output register is free and goes idle.
// collect and remaining: a fetch and an exec step per slot on the ram read port
// and the shared subtract and compare, then a final step for the last result;
// a result waiting on the output register holds the sequencer.
// reset clears armed and written flags at once, no clearing pass. ready only
// between requests.
// ----------------------------------------------------------------------------
module deadline_slot_timer_table_unit #(
	parameter int SLOTS = dstt_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// slot[2:0] arm[3] revision[35:4] generation[67:36] epoch[99:68]
	// flow_id[131:100] token[163:132] op_kind[171:164] conn[187:172]
	// deadline[251:188] now_us[315:252], zero above
	input  logic [dstt_pkg::IN_W-1:0]  s_tdata,
	// req_type[2:0]
	input  logic [2:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// out_slot[2:0] out_armed[3] out_revision[35:4] out_generation[67:36]
	// out_epoch[99:68] out_flow[131:100] out_token[163:132]
	// out_op_kind[171:164] out_conn[187:172] out_time[251:188], zero above
	output logic [dstt_pkg::OUT_W-1:0] m_tdata,
	// ok[0]
	output logic                       m_tuser,
	output logic                       m_tlast
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	dstt_pkg::state_t state_q, state_d;
	dstt_pkg::req_t   req_q;

	logic [2:0]  slot_q;
	logic        arm_q;
	logic        inrange_q;
	logic [31:0] rev_q, gen_q, ep_q, fl_q, tk_q;
	logic [7:0]  kd_q;
	logic [15:0] cn_q;
	logic [63:0] dl_q, now_q;

	logic [SW-1:0]             idx_q;
	logic [SLOTS-1:0]          armed_q;
	logic [SLOTS-1:0]          wr_q;
	logic [dstt_pkg::CNT_W-1:0] n_q;
	logic                      pend_v_q;
	dstt_pkg::res_t            pend_q;
	logic [63:0]               best_q;
	logic                      m_valid_q;
	dstt_pkg::res_t            m_res_q;

	logic [$bits(dstt_pkg::rec_t)-1:0] ram_rdata;
	dstt_pkg::rec_t rec, wrec;

	logic        accept, out_free, idx_last, slot_armed;
	logic [64:0] diff;
	logic        expired, hit, cap_hit, advance;
	logic        apply_ok, mismatch;

	// control decisions of the exec and final steps
	logic           load_out, ram_we, arm_we, arm_val, pend_load, idx_inc, n_inc;
	logic [63:0]    best_d;
	dstt_pkg::res_t res_d, pend_d;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == dstt_pkg::ST_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign idx_last = (idx_q == SW'(SLOTS - 1));

	dstt_ram #(
		.W($bits(dstt_pkg::rec_t)),
		.D(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wrec),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// a never written entry reads as cleared
	assign rec        = wr_q[idx_q] ? dstt_pkg::rec_t'(ram_rdata) : '0;
	assign slot_armed = armed_q[idx_q];

	// shared subtract: deadline minus now, borrow or zero means expired
	assign diff    = {1'b0, rec.deadline} - {1'b0, now_q};
	assign expired = diff[64] || (diff[63:0] == 64'd0);
	assign hit     = slot_armed && expired;
	assign cap_hit = hit && (n_q == dstt_pkg::CNT_W'(dstt_pkg::MAX_RES - 1));

	assign mismatch = ((gen_q != 32'd0) && (gen_q != rec.generation)) ||
		((ep_q != 32'd0) && (ep_q != rec.epoch)) ||
		((fl_q != 32'd0) && (fl_q != rec.flow)) ||
		((tk_q != 32'd0) && (tk_q != rec.token)) ||
		((kd_q != 8'd0) && (kd_q != rec.op_kind)) ||
		((cn_q != dstt_pkg::CONN_ANY) && (cn_q != rec.conn));

	always_comb begin
		apply_ok = inrange_q && (rev_q != 32'd0) && (rev_q > rec.revision);
		if (arm_q) begin
			apply_ok = apply_ok && (gen_q != 32'd0) && (tk_q != 32'd0) &&
				(kd_q != 8'd0) && (cn_q != dstt_pkg::CONN_ANY) && (dl_q != 64'd0);
		end else begin
			apply_ok = apply_ok && !(slot_armed && mismatch);
		end
	end

	always_comb begin
		wrec.revision   = rev_q;
		wrec.generation = gen_q;
		wrec.epoch      = ep_q;
		wrec.flow       = fl_q;
		wrec.token      = tk_q;
		wrec.op_kind    = kd_q;
		wrec.conn       = cn_q;
		wrec.deadline   = dl_q;
	end

	assign advance = !(hit && pend_v_q) || out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dstt_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = dstt_pkg::ST_FETCH;
				end
			end
			dstt_pkg::ST_FETCH: begin
				state_d = dstt_pkg::ST_EXEC;
			end
			dstt_pkg::ST_EXEC: begin
				unique case (req_q)
					dstt_pkg::REQ_COLLECT: begin
						if (advance) begin
							state_d = (cap_hit || idx_last) ? dstt_pkg::ST_FINAL :
								dstt_pkg::ST_FETCH;
						end
					end
					dstt_pkg::REQ_REMAIN: begin
						state_d = idx_last ? dstt_pkg::ST_FINAL : dstt_pkg::ST_FETCH;
					end
					default: begin
						if (out_free) begin
							state_d = dstt_pkg::ST_IDLE;
						end
					end
				endcase
			end
			dstt_pkg::ST_FINAL: begin
				if (out_free) begin
					state_d = dstt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dstt_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of each step
	always_comb begin
		load_out  = 1'b0;
		ram_we    = 1'b0;
		arm_we    = 1'b0;
		arm_val   = 1'b0;
		pend_load = 1'b0;
		idx_inc   = 1'b0;
		n_inc     = 1'b0;
		best_d    = best_q;
		res_d     = '0;
		res_d.last = 1'b1;

		pend_d            = '0;
		pend_d.ok         = 1'b1;
		pend_d.slot       = 3'(idx_q);
		pend_d.generation = rec.generation;
		pend_d.epoch      = rec.epoch;
		pend_d.flow       = rec.flow;
		pend_d.token      = rec.token;
		pend_d.op_kind    = rec.op_kind;
		pend_d.conn       = rec.conn;

		unique case (state_q)
			dstt_pkg::ST_EXEC: begin
				unique case (req_q)
					dstt_pkg::REQ_COLLECT: begin
						// an earlier expiry goes out once the next one is known
						if (hit && pend_v_q) begin
							load_out   = out_free;
							res_d      = pend_q;
							res_d.last = 1'b0;
						end
						if (advance) begin
							if (hit) begin
								arm_we    = 1'b1;
								pend_load = 1'b1;
								n_inc     = 1'b1;
							end
							idx_inc = !(cap_hit || idx_last);
						end
					end
					dstt_pkg::REQ_REMAIN: begin
						if (slot_armed) begin
							if (expired) begin
								best_d = 64'd0;
							end else if (diff[63:0] < best_q) begin
								best_d = diff[63:0];
							end
						end
						idx_inc = !idx_last;
					end
					dstt_pkg::REQ_APPLY: begin
						load_out   = out_free;
						res_d.slot = slot_q;
						res_d.ok   = apply_ok;
						ram_we     = apply_ok && out_free;
						arm_we     = apply_ok && out_free;
						arm_val    = arm_q;
					end
					dstt_pkg::REQ_RETIRE: begin
						load_out   = out_free;
						res_d.slot = slot_q;
						if (inrange_q && slot_armed) begin
							res_d            = pend_d;
							res_d.slot       = slot_q;
							res_d.last       = 1'b1;
							arm_we           = out_free;
						end
					end
					dstt_pkg::REQ_READ: begin
						load_out   = out_free;
						res_d.slot = slot_q;
						if (inrange_q) begin
							res_d          = pend_d;
							res_d.slot     = slot_q;
							res_d.armed    = slot_armed;
							res_d.revision = rec.revision;
							res_d.time_us  = slot_armed ? rec.deadline : 64'd0;
							res_d.last     = 1'b1;
						end
					end
					default: begin
						load_out = out_free;
					end
				endcase
			end
			dstt_pkg::ST_FINAL: begin
				load_out = out_free;
				if (req_q == dstt_pkg::REQ_REMAIN) begin
					res_d.ok      = 1'b1;
					res_d.time_us = best_q;
				end else if (pend_v_q) begin
					res_d      = pend_q;
					res_d.last = 1'b1;
				end
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dstt_pkg::ST_IDLE;
			armed_q   <= '0;
			wr_q      <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			pend_v_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				n_q      <= '0;
				pend_v_q <= 1'b0;
				if ((dstt_pkg::req_t'(s_tuser) == dstt_pkg::REQ_COLLECT) ||
					(dstt_pkg::req_t'(s_tuser) == dstt_pkg::REQ_REMAIN)) begin
					idx_q <= '0;
				end else begin
					idx_q <= SW'(s_tdata[2:0]);
				end
			end else if (idx_inc) begin
				idx_q <= idx_q + SW'(1);
			end
			if (n_inc) begin
				n_q <= n_q + dstt_pkg::CNT_W'(1);
			end
			if (pend_load) begin
				pend_v_q <= 1'b1;
			end
			if (arm_we) begin
				armed_q[idx_q] <= arm_val;
			end
			if (ram_we) begin
				wr_q[idx_q] <= 1'b1;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// request fields and payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= dstt_pkg::req_t'(s_tuser);
			slot_q    <= s_tdata[2:0];
			inrange_q <= (32'(s_tdata[2:0]) < SLOTS);
			arm_q     <= s_tdata[3];
			rev_q     <= s_tdata[35:4];
			gen_q     <= s_tdata[67:36];
			ep_q      <= s_tdata[99:68];
			fl_q      <= s_tdata[131:100];
			tk_q      <= s_tdata[163:132];
			kd_q      <= s_tdata[171:164];
			cn_q      <= s_tdata[187:172];
			dl_q      <= s_tdata[251:188];
			now_q     <= s_tdata[315:252];
			best_q    <= dstt_pkg::TIME_ALL;
		end else begin
			best_q <= best_d;
		end
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (load_out) begin
			m_res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.ok;
	assign m_tlast  = m_res_q.last;
	assign m_tdata  = {4'd0, m_res_q.time_us, m_res_q.conn, m_res_q.op_kind,
		m_res_q.token, m_res_q.flow, m_res_q.epoch, m_res_q.generation,
		m_res_q.revision, m_res_q.armed, m_res_q.slot};

endmodule

// ===== rtl/core/dstt_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstt_chk
// port level checks of the deadline slot timer table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dstt_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [dstt_pkg::OUT_W-1:0] m_tdata,
	input logic                       m_tuser,
	input logic                       m_tlast
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	// a stalled result holds
	`DSTT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> $stable({m_tvalid, m_tdata, m_tuser, m_tlast}))

	// one request at a time
	`DSTT_ASSERT(a_busy_after_req, s_acc |=> !s_tready)

	// only collect expiries come before the last result, and they report ok
	`DSTT_ASSERT(a_mid_ok, m_tvalid && !m_tlast |-> m_tuser)

	// no new request while a request still has results to give
	`DSTT_ASSERT(a_mid_busy, m_tvalid && !m_tlast |-> !s_tready)

	// nothing leaves during reset
	`DSTT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_tvalid)

endmodule

bind deadline_slot_timer_table_unit dstt_chk u_dstt_chk (.*);

// ===== verif/dstt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstt_table_checker
// watches both streams of the deadline slot timer table, keeps its own copy
// of the slot table, works out the results of every accepted request and
// compares each returned result with the oldest one still awaited
// ----------------------------------------------------------------------------
module dstt_table_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [dstt_pkg::IN_W-1:0]  s_tdata,
	input  logic [2:0]                 s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [dstt_pkg::OUT_W-1:0] m_tdata,
	input  logic                       m_tuser,
	input  logic                       m_tlast,
	output int                         err_count,
	output int                         outstanding
);
	import dstt_pkg::*;

	localparam int SLOT_COUNT = SLOTS_DEF;

	logic        t_armed    [SLOT_COUNT];
	logic [31:0] t_rev      [SLOT_COUNT];
	logic [31:0] t_gen      [SLOT_COUNT];
	logic [31:0] t_epoch    [SLOT_COUNT];
	logic [31:0] t_flow     [SLOT_COUNT];
	logic [31:0] t_token    [SLOT_COUNT];
	logic [7:0]  t_kind     [SLOT_COUNT];
	logic [15:0] t_conn     [SLOT_COUNT];
	logic [63:0] t_deadline [SLOT_COUNT];

	res_t awaited_results[$];
	int   mismatches;

	assign err_count = mismatches;

	function automatic res_t with_identity(res_t r, int i);
		r.generation = t_gen[i];
		r.epoch      = t_epoch[i];
		r.flow       = t_flow[i];
		r.token      = t_token[i];
		r.op_kind    = t_kind[i];
		r.conn       = t_conn[i];
		return r;
	endfunction

	// zero matches anything on disarm
	function automatic logic differs32(logic [31:0] want, logic [31:0] have);
		return want != '0 && want != have;
	endfunction

	// updates the table copy and queues the results the request must give
	task automatic forecast_results(input logic [2:0] code, input logic [IN_W-1:0] d);
		logic [2:0]  idx;
		logic        arm;
		logic [31:0] rev, gen, ep, fl, tk;
		logic [7:0]  kd;
		logic [15:0] cn;
		logic [63:0] dl, now_us, least;
		logic        refused;
		int          hits[$];
		res_t        r;
		idx    = d[2:0];
		arm    = d[3];
		rev    = d[35:4];
		gen    = d[67:36];
		ep     = d[99:68];
		fl     = d[131:100];
		tk     = d[163:132];
		kd     = d[171:164];
		cn     = d[187:172];
		dl     = d[251:188];
		now_us = d[315:252];
		r      = '0;
		case (code)
			REQ_APPLY: begin
				r.slot  = idx;
				refused = rev == '0 || rev <= t_rev[idx];
				if (!refused) begin
					if (arm) begin
						refused = gen == '0 || tk == '0 || kd == '0 || cn == CONN_ANY
							|| dl == '0;
					end else if (t_armed[idx]) begin
						refused = differs32(gen, t_gen[idx]) || differs32(ep, t_epoch[idx])
							|| differs32(fl, t_flow[idx]) || differs32(tk, t_token[idx])
							|| (kd != '0 && kd != t_kind[idx])
							|| (cn != CONN_ANY && cn != t_conn[idx]);
					end
				end
				if (!refused) begin
					t_armed[idx]    = arm;
					t_rev[idx]      = rev;
					t_gen[idx]      = gen;
					t_epoch[idx]    = ep;
					t_flow[idx]     = fl;
					t_token[idx]    = tk;
					t_kind[idx]     = kd;
					t_conn[idx]     = cn;
					t_deadline[idx] = arm ? dl : '0;
				end
				r.ok = !refused;
			end
			REQ_COLLECT: begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (t_armed[i] && t_deadline[i] <= now_us && hits.size() < MAX_RES)
						hits.push_back(i);
				// nothing due still gives one empty result
				if (hits.size() == 0) begin
					r.last = 1'b1;
					awaited_results.push_back(r);
				end
				foreach (hits[k]) begin
					r      = with_identity('0, hits[k]);
					r.ok   = 1'b1;
					r.slot = 3'(hits[k]);
					r.last = k == hits.size() - 1;
					t_armed[hits[k]]    = 1'b0;
					t_deadline[hits[k]] = '0;
					awaited_results.push_back(r);
				end
			end
			REQ_RETIRE: begin
				r.slot = idx;
				if (t_armed[idx]) begin
					r    = with_identity(r, idx);
					r.ok = 1'b1;
					t_armed[idx]    = 1'b0;
					t_deadline[idx] = '0;
				end
			end
			REQ_REMAIN: begin
				least = TIME_ALL;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (t_armed[i]) begin
						if (t_deadline[i] <= now_us) begin
							least = '0;
							break;
						end
						if (t_deadline[i] - now_us < least)
							least = t_deadline[i] - now_us;
					end
				end
				r.ok      = 1'b1;
				r.time_us = least;
			end
			REQ_READ: begin
				r          = with_identity(r, idx);
				r.ok       = 1'b1;
				r.slot     = idx;
				r.armed    = t_armed[idx];
				r.revision = t_rev[idx];
				r.time_us  = t_deadline[idx];
			end
			default: ;
		endcase
		if (code != REQ_COLLECT) begin
			r.last = 1'b1;
			awaited_results.push_back(r);
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				t_armed[i]    = 1'b0;
				t_rev[i]      = '0;
				t_gen[i]      = '0;
				t_epoch[i]    = '0;
				t_flow[i]     = '0;
				t_token[i]    = '0;
				t_kind[i]     = '0;
				t_conn[i]     = '0;
				t_deadline[i] = '0;
			end
			awaited_results.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual slot %0d ok %0b",
						$time, m_tdata[2:0], m_tuser);
					mismatches++;
				end else begin
					check_field("ok", awaited_results[0].ok, m_tuser);
					check_field("out_slot", awaited_results[0].slot, m_tdata[2:0]);
					check_field("out_armed", awaited_results[0].armed, m_tdata[3]);
					check_field("out_revision", awaited_results[0].revision, m_tdata[35:4]);
					check_field("out_generation", awaited_results[0].generation,
						m_tdata[67:36]);
					check_field("out_epoch", awaited_results[0].epoch, m_tdata[99:68]);
					check_field("out_flow", awaited_results[0].flow, m_tdata[131:100]);
					check_field("out_token", awaited_results[0].token, m_tdata[163:132]);
					check_field("out_op_kind", awaited_results[0].op_kind, m_tdata[171:164]);
					check_field("out_conn", awaited_results[0].conn, m_tdata[187:172]);
					check_field("out_time", awaited_results[0].time_us, m_tdata[251:188]);
					check_field("last", awaited_results[0].last, m_tlast);
					void'(awaited_results.pop_front());
				end
			end
			if (s_tvalid && s_tready)
				forecast_results(s_tuser, s_tdata);
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random requests into the deadline slot timer table,
// with random gaps on the request side and random stalls on the result side;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
	import dstt_pkg::*;

	localparam logic [2:0] REQ_ODD_LO    = 3'd5;
	localparam logic [2:0] REQ_ODD_HI    = 3'd7;
	localparam int         RANDOM_ITEMS  = 152;
	localparam int         SETTLE_CYCLES = 40;
	localparam int         CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [2:0]  code;
		logic [2:0]  slot;
		logic        arm;
		logic [31:0] rev, gen, epoch, flow, token;
		logic [7:0]  op_kind;
		logic [15:0] conn;
		logic [63:0] deadline, now_us;
	} timer_req_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [2:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              m_tlast;
	int                err_count;
	int                outstanding;
	int                cycles = 0;
	logic              calm;

	// stimulus bookkeeping: next newer revision and last armed identity per slot
	logic [31:0] next_rev [SLOTS_DEF];
	timer_req_t  last_arm [SLOTS_DEF];
	logic [63:0] clock_us;

	deadline_slot_timer_table_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	dstt_table_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.err_count  (err_count),
		.outstanding(outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL deadline_slot_timer_table_unit");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= calm || $urandom_range(0, 99) >= 18;

	function automatic timer_req_t apply_req(input logic [2:0] slot, input logic arm,
		input logic [31:0] rev, gen, ep, fl, tk, input logic [7:0] kd,
		input logic [15:0] cn, input logic [63:0] dl);
		timer_req_t r;
		r          = '0;
		r.code     = REQ_APPLY;
		r.slot     = slot;
		r.arm      = arm;
		r.rev      = rev;
		r.gen      = gen;
		r.epoch    = ep;
		r.flow     = fl;
		r.token    = tk;
		r.op_kind  = kd;
		r.conn     = cn;
		r.deadline = dl;
		return r;
	endfunction

	function automatic timer_req_t plain_req(input logic [2:0] code, input logic [2:0] slot,
		input logic [63:0] now_us);
		timer_req_t r;
		r        = '0;
		r.code   = code;
		r.slot   = slot;
		r.now_us = now_us;
		return r;
	endfunction

	task automatic issue(input timer_req_t r);
		if (!calm && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 21)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.code;
		s_tdata  <= {4'b0, r.now_us, r.deadline, r.conn, r.op_kind, r.token, r.flow,
			r.epoch, r.gen, r.rev, r.arm, r.slot};
		do @(posedge clk); while (!s_tready);
		if (r.code == REQ_APPLY && r.rev >= next_rev[r.slot] && r.rev != '1)
			next_rev[r.slot] = r.rev + 1;
	endtask

	// hold back until every awaited result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		timer_req_t  r;
		int          s;
		int          pick;
		logic [63:0] t;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		calm     = 1'b0;
		clock_us = 64'd1000;
		foreach (next_rev[i]) begin
			next_rev[i] = 32'd1;
			last_arm[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: read, remaining and collect on nothing armed
		issue(plain_req(REQ_READ, 3'd3, '0));
		issue(plain_req(REQ_REMAIN, 3'd0, '0));
		issue(plain_req(REQ_COLLECT, 3'd0, '1));
		issue(plain_req(REQ_ODD_LO, 3'd5, '1));
		issue(plain_req(REQ_ODD_HI, 3'd7, '0));
		// refused arms: missing token, zero revision, any-connection, no kind, no deadline
		issue(apply_req(3'd7, 1'b1, '1, 32'd1, '0, '0, '0, 8'd1, 16'd0, 64'd1));
		issue(apply_req(3'd0, 1'b1, '0, 32'd1, 32'd1, 32'd1, 32'd1, 8'd1, 16'd0, 64'd5));
		issue(apply_req(3'd1, 1'b1, next_rev[1], 32'd1, 32'd1, 32'd1, 32'd1, 8'd1,
			CONN_ANY, 64'd5));
		issue(apply_req(3'd1, 1'b1, next_rev[1], 32'd1, 32'd1, 32'd1, 32'd1, '0,
			16'd0, 64'd5));
		issue(apply_req(3'd1, 1'b1, next_rev[1], 32'd1, 32'd1, 32'd1, 32'd1, 8'd1,
			16'd0, '0));
		// fill every slot, slot 0 never due before the end of time
		for (int k = 0; k < SLOTS_DEF; k++)
			issue(apply_req(3'(k), 1'b1, next_rev[k], 32'hFFFF_FFFF - k, 32'(k), ~32'(k),
				32'hFFFF_FFFF, 8'hFF - 8'(k), 16'hFFFE - 16'(k),
				k == 0 ? '1 : 64'(100 * k)));
		issue(plain_req(REQ_REMAIN, 3'd0, 64'd50));
		issue(plain_req(REQ_COLLECT, 3'd0, '1));
		// stale revision, then identity-checked disarms
		issue(apply_req(3'd4, 1'b1, 32'd1, 32'd9, 32'd9, 32'd9, 32'd9, 8'd9, 16'd9, 64'd9));
		issue(apply_req(3'd2, 1'b1, next_rev[2], 32'd7, 32'd8, 32'd9, 32'd10, 8'd11,
			16'd12, 64'd5000));
		issue(apply_req(3'd3, 1'b1, next_rev[3], 32'd3, 32'd3, 32'd3, 32'd3, 8'd3,
			16'd3, 64'd6000));
		issue(apply_req(3'd2, 1'b0, next_rev[2], 32'd7, 32'd8, 32'd9, 32'd99, 8'd11,
			16'd12, '0));
		issue(apply_req(3'd2, 1'b0, next_rev[2], '0, '0, '0, '0, '0, CONN_ANY, '0));
		issue(plain_req(REQ_READ, 3'd2, '0));
		issue(plain_req(REQ_RETIRE, 3'd3, '0));
		issue(plain_req(REQ_RETIRE, 3'd3, '0));
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= n >= 60 && n < 110;
			s    = $urandom_range(0, SLOTS_DEF - 1);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				r = apply_req(3'(s), 1'b1, next_rev[s], $urandom_range(1, 32'hFFFF_FFFF),
					$urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF),
					8'($urandom_range(1, 255)), 16'($urandom_range(0, 16'hFFFE)),
					clock_us + $urandom_range(1, 400));
				last_arm[s] = r;
			end else if (pick < 42) begin
				r     = last_arm[s];
				r.arm = 1'b0;
				r.rev = next_rev[s];
				if ($urandom_range(0, 1)) r.gen = '0;
				if ($urandom_range(0, 1)) r.epoch = '0;
				if ($urandom_range(0, 1)) r.flow = '0;
				if ($urandom_range(0, 1)) r.token = '0;
				if ($urandom_range(0, 1)) r.op_kind = '0;
				if ($urandom_range(0, 1)) r.conn = CONN_ANY;
				if ($urandom_range(0, 99) < 15) r.flow = r.flow ^ 32'h1;
			end else if (pick < 57) begin
				clock_us = clock_us + $urandom_range(0, 200);
				t = clock_us;
				// land exactly on a deadline now and then
				if ($urandom_range(0, 99) < 20) t = last_arm[$urandom_range(0, 7)].deadline;
				r = plain_req(REQ_COLLECT, 3'(s), t);
			end else if (pick < 67) begin
				clock_us = clock_us + $urandom_range(0, 200);
				r = plain_req(REQ_REMAIN, 3'(s), clock_us);
			end else if (pick < 77) begin
				r = plain_req(REQ_RETIRE, 3'(s), '0);
			end else if (pick < 87) begin
				r = plain_req(REQ_READ, 3'(s), '0);
			end else begin
				r = apply_req(3'(s), 1'($urandom), $urandom & 32'h7FFF_FFFF, $urandom,
					$urandom, $urandom, $urandom, 8'($urandom), 16'($urandom),
					{$urandom, $urandom});
				r.code   = 3'($urandom_range(0, 7));
				r.now_us = {$urandom, $urandom};
			end
			issue(r);
			if (n % 30 == 29)
				drain();
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS deadline_slot_timer_table_unit");
		else
			$display("FAIL deadline_slot_timer_table_unit");
		$finish;
	end

endmodule
